/* hdl/gregorian_day_number_converter_assert.svh */
// assertion macros for the day number converter checker
`ifndef GREGORIAN_DAY_NUMBER_CONVERTER_ASSERT_SVH
`define GREGORIAN_DAY_NUMBER_CONVERTER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define GDN_ASSERT_IMP(name, clk_sig, rst_n_sig, ante, cons) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("gdn check failed");

// next-cycle implication, disabled while reset is low
`define GDN_ASSERT_NXT(name, clk_sig, rst_n_sig, ante, cons) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error("gdn check failed");

`endif

/* hdl/gdn_pkg.sv */
// types, constants and tables for the gregorian day number converter
package gdn_pkg;

	typedef enum logic {
		ACT_TO_DAY_NUMBER = 1'b0,
		ACT_TO_DATE       = 1'b1
	} action_t;

	localparam int YEAR_W  = 15;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DN_W    = 23;
	localparam int WD_W    = 3;
	// year + 4800, always non-negative inside the supported range
	localparam int EY_W    = 14;

	typedef logic signed [YEAR_W-1:0] year_t;
	typedef logic [MONTH_W-1:0]       month_t;
	typedef logic [DAY_W-1:0]         day_t;
	typedef logic [DN_W-1:0]          dn_t;
	typedef logic [WD_W-1:0]          wd_t;
	typedef logic [EY_W-1:0]          ey_t;
	typedef logic [8:0]               mstart_t;

	localparam dn_t   DAY_NUMBER_MAX = 23'd5373484;
	localparam year_t YEAR_MIN       = -15'sd4713;
	localparam year_t YEAR_MAX       = 15'sd9999;

	localparam int YEAR_BIAS        = 4800;
	localparam int JDN_BIAS_TO_DATE = 32044;
	localparam int JDN_BIAS_TO_NUM  = 32045;
	localparam int DAYS_400Y        = 146097;
	localparam int DAYS_100Y        = 36524;
	localparam int DAYS_4Y          = 1461;
	localparam int DAYS_1Y          = 365;
	localparam int DAYS_WEEK        = 7;
	localparam int YEARS_400        = 400;
	localparam int YEARS_100        = 100;
	localparam int MONTHS_PER_YEAR  = 12;
	localparam int MONTH_MAX        = 12;
	localparam int EARLY_MONTHS     = 2;
	// march-based month index of january
	localparam month_t MI_JAN       = 4'd10;

	// reciprocal constants: q = (x * K) >> SH, exact over the operand range
	localparam int          DIV100_SH  = 21;
	localparam logic [14:0] DIV100_K   = 15'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);
	localparam int          Q100_W     = 8;
	localparam int          DIV7_SH    = 26;
	localparam logic [23:0] DIV7_K     = 24'(((64'd1 << DIV7_SH) + 64'd6) / 64'd7);
	localparam int          Q7_W       = 21;
	localparam int          DIV400Y_SH = 41;
	localparam logic [23:0] DIV400Y_K  = 24'(((64'd1 << DIV400Y_SH) + 64'd146096) / 64'd146097);
	localparam int          G_W        = 6;
	localparam int          DIV4Y_SH   = 27;
	localparam logic [16:0] DIV4Y_K    = 17'(((64'd1 << DIV4Y_SH) + 64'd1460) / 64'd1461);
	localparam int          B_W        = 5;

	// days before the start of a march-based month (0 = march)
	function automatic mstart_t month_start(input month_t mi);
		mstart_t days;
		unique case (mi)
			4'd0:    days = 9'd0;
			4'd1:    days = 9'd31;
			4'd2:    days = 9'd61;
			4'd3:    days = 9'd92;
			4'd4:    days = 9'd122;
			4'd5:    days = 9'd153;
			4'd6:    days = 9'd184;
			4'd7:    days = 9'd214;
			4'd8:    days = 9'd245;
			4'd9:    days = 9'd275;
			4'd10:   days = 9'd306;
			4'd11:   days = 9'd337;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

endpackage

/* hdl/gregorian_day_number_converter.sv */
// gregorian date <-> julian day number converter, eleven-stage pipeline
//
//   channel   handshake              payload
//   request   req_valid/req_ready    action, year_in, month_in, day_in, day_number_in
//   response  rsp_valid/rsp_ready    day_number_out, year_out, month_out, day_out,
//                                    weekday, leap_flag, range_err
//
// eleven register stages: the response is valid once its request has passed all
// of them, one request per cycle sustained while the response side is ready
// each stage is about one constant multiply (reciprocal division) or one
// compare-subtract deep
// reset clears the stage valid bits only, the datapath registers are not reset
// a stalled response holds its register; earlier stages keep moving into empty
// slots, so requests are still taken until the pipeline is full
module gregorian_day_number_converter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  gdn_pkg::action_t action,
	input  gdn_pkg::year_t   year_in,
	input  gdn_pkg::month_t  month_in,
	input  gdn_pkg::day_t    day_in,
	input  gdn_pkg::dn_t     day_number_in,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output gdn_pkg::dn_t     day_number_out,
	output gdn_pkg::year_t   year_out,
	output gdn_pkg::month_t  month_out,
	output gdn_pkg::day_t    day_out,
	output gdn_pkg::wd_t     weekday,
	output logic             leap_flag,
	output logic             range_err
);
	import gdn_pkg::*;

	localparam int NUM_STAGES = 11;

	// stage enables, rippled back from the response register
	logic [NUM_STAGES:1] stage_en;

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;

	// stage 1: bias the inputs, month table, range checks
	action_t act_s1;
	logic    oor_s1, a_s1;
	ey_t     y_s1;
	mstart_t md_s1;
	dn_t     j_s1, jdn_s1;
	logic    date_bad_c, num_bad_c, early_c;
	ey_t     ey_c1, y_c1;
	month_t  mi_c1;

	// stage 2: reciprocal divisions by 100, 7 and the 400-year cycle
	action_t act_s2;
	logic    oor_s2, a_s2;
	ey_t     y_s2;
	mstart_t md_s2;
	logic [Q100_W-1:0] q100y_s2;
	dn_t     j_s2, jdn_s2;
	logic [G_W-1:0]   g_s2;
	logic [Q7_W-1:0]  q7_s2;
	logic [28:0] prod_100y;
	logic [46:0] prod_g, prod_7;

	// stage 3: day number sum, remainders
	action_t act_s3;
	logic    oor_s3;
	logic signed [24:0] jd_s3;
	logic [17:0] dg_s3;
	ey_t     yp_s3;
	wd_t     wd_s3;
	logic signed [24:0] jd_c3;
	logic [17:0] dg_c3;
	ey_t     yp_c3;
	dn_t     r7_c3;

	// stage 4: century within the 400-year cycle
	action_t act_s4;
	logic    oor_s4;
	dn_t     dn_s4;
	logic [15:0] dc_s4;
	ey_t     yp_s4;
	wd_t     wd_s4;
	logic [1:0]  c_c4;
	logic        jd_bad_c4;

	// stage 5: 4-year cycle index
	action_t act_s5;
	logic    oor_s5;
	dn_t     dn_s5;
	logic [15:0] dc_s5;
	logic [B_W-1:0] b_s5;
	ey_t     yp_s5;
	wd_t     wd_s5;
	logic [32:0] prod_b;

	// stage 6: day within the 4-year cycle
	action_t act_s6;
	logic    oor_s6;
	dn_t     dn_s6;
	logic [10:0] db_s6;
	ey_t     yp_s6;
	wd_t     wd_s6;

	// stage 7: year within the 4-year cycle
	action_t act_s7;
	logic    oor_s7;
	dn_t     dn_s7;
	logic [8:0]  da_s7;
	ey_t     yp_s7;
	wd_t     wd_s7;
	logic [1:0]  a_c7;

	// stage 8: month search
	action_t act_s8;
	logic    oor_s8;
	dn_t     dn_s8;
	month_t  mi_s8;
	day_t    d_s8;
	ey_t     yp_s8;
	wd_t     wd_s8;
	month_t  mi_c8;

	// stage 9: result fields
	logic    oor_s9;
	ey_t     ey_s9;
	dn_t     dn_s9;
	year_t   yr_s9;
	month_t  mo_s9;
	day_t    dy_s9;
	wd_t     wd_s9;
	logic    roll_c9;
	ey_t     ey_c9;

	// stage 10: leap-year division
	logic    oor_s10;
	ey_t     ey_s10;
	logic [Q100_W-1:0] q100e_s10;
	dn_t     dn_s10;
	year_t   yr_s10;
	month_t  mo_s10;
	day_t    dy_s10;
	wd_t     wd_s10;
	logic [28:0] prod_100e;

	// stage 11: response register
	logic    oor_s11, leap_s11;
	dn_t     dn_s11;
	year_t   yr_s11;
	month_t  mo_s11;
	day_t    dy_s11;
	wd_t     wd_s11;
	logic    leap_c11;

	// a stage moves when it is empty or the one after it moves
	assign stage_en[11] = !v_s11 || rsp_ready;
	assign stage_en[10] = !v_s10 || stage_en[11];
	assign stage_en[9]  = !v_s9  || stage_en[10];
	assign stage_en[8]  = !v_s8  || stage_en[9];
	assign stage_en[7]  = !v_s7  || stage_en[8];
	assign stage_en[6]  = !v_s6  || stage_en[7];
	assign stage_en[5]  = !v_s5  || stage_en[6];
	assign stage_en[4]  = !v_s4  || stage_en[5];
	assign stage_en[3]  = !v_s3  || stage_en[4];
	assign stage_en[2]  = !v_s2  || stage_en[3];
	assign stage_en[1]  = !v_s1  || stage_en[2];

	assign req_ready = stage_en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			if (stage_en[1])  v_s1  <= req_valid;
			if (stage_en[2])  v_s2  <= v_s1;
			if (stage_en[3])  v_s3  <= v_s2;
			if (stage_en[4])  v_s4  <= v_s3;
			if (stage_en[5])  v_s5  <= v_s4;
			if (stage_en[6])  v_s6  <= v_s5;
			if (stage_en[7])  v_s7  <= v_s6;
			if (stage_en[8])  v_s8  <= v_s7;
			if (stage_en[9])  v_s9  <= v_s8;
			if (stage_en[10]) v_s10 <= v_s9;
			if (stage_en[11]) v_s11 <= v_s10;
		end
	end

	// ---------------------------------------------------------------- stage 1
	// date side works on y = year + 4800 - a with a march-based month index,
	// so every floor division below sees a non-negative operand
	always_comb begin
		date_bad_c = (year_in < YEAR_MIN) || (year_in > YEAR_MAX) || (month_in == '0)
			|| (month_in > MONTH_W'(MONTH_MAX)) || (day_in == '0);
		num_bad_c  = day_number_in > DAY_NUMBER_MAX;
		early_c    = month_in <= MONTH_W'(EARLY_MONTHS);
		ey_c1      = EY_W'(year_in + YEAR_W'(YEAR_BIAS));
		y_c1       = ey_c1 - EY_W'(early_c);
		mi_c1      = early_c ? month_in + 4'd9 : month_in - 4'd3;
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			act_s1 <= action;
			oor_s1 <= (action == ACT_TO_DATE) ? num_bad_c : date_bad_c;
			a_s1   <= early_c;
			y_s1   <= y_c1;
			md_s1  <= 9'(day_in) + month_start(mi_c1);
			j_s1   <= day_number_in + DN_W'(JDN_BIAS_TO_DATE);
			jdn_s1 <= day_number_in;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// floor divisions by constant reciprocal multiply
	always_comb begin
		prod_100y = 29'(y_s1) * 29'(DIV100_K);
		prod_g    = 47'(j_s1) * 47'(DIV400Y_K);
		prod_7    = 47'(jdn_s1) * 47'(DIV7_K);
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			act_s2   <= act_s1;
			oor_s2   <= oor_s1;
			a_s2     <= a_s1;
			y_s2     <= y_s1;
			md_s2    <= md_s1;
			q100y_s2 <= prod_100y[DIV100_SH +: Q100_W];
			j_s2     <= j_s1;
			g_s2     <= prod_g[DIV400Y_SH +: G_W];
			jdn_s2   <= jdn_s1;
			q7_s2    <= prod_7[DIV7_SH +: Q7_W];
		end
	end

	// ---------------------------------------------------------------- stage 3
	// date side: day + month days + 365y + y/4 - y/100 + y/400 - 32045
	// with y/400 taken as (y/100)/4
	// number side: day within the 400-year cycle and the weekday
	always_comb begin
		jd_c3 = 25'(md_s2) + 25'(y_s2) * 25'(DAYS_1Y) + 25'(y_s2 >> 2) - 25'(q100y_s2)
			+ 25'(q100y_s2 >> 2) - 25'(JDN_BIAS_TO_NUM);
		dg_c3 = 18'(j_s2 - DN_W'(g_s2) * DN_W'(DAYS_400Y));
		r7_c3 = jdn_s2 - DN_W'(q7_s2) * DN_W'(DAYS_WEEK);
		// year accumulator: 400g on the number side, year + 4800 on the date side
		yp_c3 = (act_s2 == ACT_TO_DATE) ? EY_W'(g_s2) * EY_W'(YEARS_400)
			: y_s2 + EY_W'(a_s2);
	end

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			act_s3 <= act_s2;
			oor_s3 <= oor_s2;
			jd_s3  <= jd_c3;
			dg_s3  <= dg_c3;
			yp_s3  <= yp_c3;
			wd_s3  <= WD_W'(r7_c3) + 3'd1;
		end
	end

	// ---------------------------------------------------------------- stage 4
	// century c = min(dg / 36524, 3) by threshold compare
	always_comb begin
		c_c4 = 2'(dg_s3 >= 18'(DAYS_100Y)) + 2'(dg_s3 >= 18'(2 * DAYS_100Y))
			+ 2'(dg_s3 >= 18'(3 * DAYS_100Y));
		jd_bad_c4 = (jd_s3 < 25'sd0) || (jd_s3 > $signed(25'(DAY_NUMBER_MAX)));
	end

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			act_s4 <= act_s3;
			oor_s4 <= oor_s3 || ((act_s3 == ACT_TO_DAY_NUMBER) && jd_bad_c4);
			dn_s4  <= jd_s3[DN_W-1:0];
			dc_s4  <= 16'(dg_s3 - 18'(c_c4) * 18'(DAYS_100Y));
			yp_s4  <= (act_s3 == ACT_TO_DATE) ? yp_s3 + EY_W'(c_c4) * EY_W'(YEARS_100)
				: yp_s3;
			wd_s4  <= wd_s3;
		end
	end

	// ---------------------------------------------------------------- stage 5
	assign prod_b = 33'(dc_s4) * 33'(DIV4Y_K);

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			act_s5 <= act_s4;
			oor_s5 <= oor_s4;
			dn_s5  <= dn_s4;
			dc_s5  <= dc_s4;
			b_s5   <= prod_b[DIV4Y_SH +: B_W];
			yp_s5  <= yp_s4;
			wd_s5  <= wd_s4;
		end
	end

	// ---------------------------------------------------------------- stage 6
	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			act_s6 <= act_s5;
			oor_s6 <= oor_s5;
			dn_s6  <= dn_s5;
			db_s6  <= 11'(dc_s5 - 16'(b_s5) * 16'(DAYS_4Y));
			yp_s6  <= (act_s5 == ACT_TO_DATE) ? yp_s5 + EY_W'({b_s5, 2'b00}) : yp_s5;
			wd_s6  <= wd_s5;
		end
	end

	// ---------------------------------------------------------------- stage 7
	// year in the 4-year cycle a = min(db / 365, 3)
	assign a_c7 = 2'(db_s6 >= 11'(DAYS_1Y)) + 2'(db_s6 >= 11'(2 * DAYS_1Y))
		+ 2'(db_s6 >= 11'(3 * DAYS_1Y));

	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			act_s7 <= act_s6;
			oor_s7 <= oor_s6;
			dn_s7  <= dn_s6;
			da_s7  <= 9'(db_s6 - 11'(a_c7) * 11'(DAYS_1Y));
			yp_s7  <= (act_s6 == ACT_TO_DATE) ? yp_s6 + EY_W'(a_c7) : yp_s6;
			wd_s7  <= wd_s6;
		end
	end

	// ---------------------------------------------------------------- stage 8
	// march-based month: count of month starts at or below the day of year
	always_comb begin
		mi_c8 = '0;
		for (int k = 1; k < MONTHS_PER_YEAR; k++) begin
			mi_c8 = mi_c8 + MONTH_W'(da_s7 >= month_start(MONTH_W'(k)));
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[8]) begin
			act_s8 <= act_s7;
			oor_s8 <= oor_s7;
			dn_s8  <= dn_s7;
			mi_s8  <= mi_c8;
			d_s8   <= DAY_W'(da_s7 - month_start(mi_c8));
			yp_s8  <= yp_s7;
			wd_s8  <= wd_s7;
		end
	end

	// ---------------------------------------------------------------- stage 9
	// january and february belong to the next calendar year
	always_comb begin
		roll_c9 = mi_s8 >= MI_JAN;
		ey_c9   = (act_s8 == ACT_TO_DATE) ? yp_s8 + EY_W'(roll_c9) : yp_s8;
	end

	always_ff @(posedge clk) begin
		if (stage_en[9]) begin
			oor_s9 <= oor_s8;
			ey_s9  <= ey_c9;
			dn_s9  <= (!oor_s8 && (act_s8 == ACT_TO_DAY_NUMBER)) ? dn_s8 : '0;
			if (!oor_s8 && (act_s8 == ACT_TO_DATE)) begin
				yr_s9 <= $signed({1'b0, ey_c9}) - YEAR_W'(YEAR_BIAS);
				mo_s9 <= roll_c9 ? mi_s8 - 4'd9 : mi_s8 + 4'd3;
				dy_s9 <= d_s8 + 5'd1;
				wd_s9 <= wd_s8;
			end else begin
				yr_s9 <= '0;
				mo_s9 <= '0;
				dy_s9 <= '0;
				wd_s9 <= '0;
			end
		end
	end

	// --------------------------------------------------------------- stage 10
	assign prod_100e = 29'(ey_s9) * 29'(DIV100_K);

	always_ff @(posedge clk) begin
		if (stage_en[10]) begin
			oor_s10   <= oor_s9;
			ey_s10    <= ey_s9;
			q100e_s10 <= prod_100e[DIV100_SH +: Q100_W];
			dn_s10    <= dn_s9;
			yr_s10    <= yr_s9;
			mo_s10    <= mo_s9;
			dy_s10    <= dy_s9;
			wd_s10    <= wd_s9;
		end
	end

	// --------------------------------------------------------------- stage 11
	// 4800 is a multiple of 400, so the biased year gives the same leap rule
	assign leap_c11 = !oor_s10 && (ey_s10[1:0] == 2'b00)
		&& ((ey_s10 != EY_W'(q100e_s10) * EY_W'(YEARS_100)) || (q100e_s10[1:0] == 2'b00));

	always_ff @(posedge clk) begin
		if (stage_en[11]) begin
			oor_s11  <= oor_s10;
			leap_s11 <= leap_c11;
			dn_s11   <= dn_s10;
			yr_s11   <= yr_s10;
			mo_s11   <= mo_s10;
			dy_s11   <= dy_s10;
			wd_s11   <= wd_s10;
		end
	end

	assign rsp_valid      = v_s11;
	assign day_number_out = dn_s11;
	assign year_out       = yr_s11;
	assign month_out      = mo_s11;
	assign day_out        = dy_s11;
	assign weekday        = wd_s11;
	assign leap_flag      = leap_s11;
	assign range_err      = oor_s11;

endmodule

/* hdl/gdn_checker.sv */
// port-level checks for the day number converter and their bind
`include "gregorian_day_number_converter_assert.svh"

module gdn_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input gdn_pkg::dn_t     day_number_out,
	input gdn_pkg::year_t   year_out,
	input gdn_pkg::month_t  month_out,
	input gdn_pkg::day_t    day_out,
	input gdn_pkg::wd_t     weekday,
	input logic             leap_flag,
	input logic             range_err
);
	import gdn_pkg::*;

	logic rest_zero, date_ok, num_ok;
	logic [DN_W+YEAR_W+MONTH_W+DAY_W+WD_W+1:0] rsp_word;

	assign rest_zero = (day_number_out == '0) && (year_out == '0) && (month_out == '0)
		&& (day_out == '0) && (weekday == '0) && !leap_flag;
	assign date_ok = (day_number_out == '0) && (month_out != '0)
		&& (month_out <= MONTH_W'(MONTH_MAX)) && (day_out != '0);
	assign num_ok = (year_out == '0) && (month_out == '0) && (day_out == '0)
		&& (day_number_out <= DAY_NUMBER_MAX);
	assign rsp_word = {day_number_out, year_out, month_out, day_out, weekday, leap_flag,
		range_err};

	// an out-of-range response carries nothing else
	`GDN_ASSERT_IMP(a_oor_zero, clk, arst_n, rsp_valid && range_err, rest_zero)

	// a date response has a weekday, a real month and day, and no day number
	`GDN_ASSERT_IMP(a_date_shape, clk, arst_n, rsp_valid && !range_err && (weekday != '0), date_ok)

	// a day number response has no date fields and stays in range
	`GDN_ASSERT_IMP(a_dn_shape, clk, arst_n, rsp_valid && !range_err && (weekday == '0), num_ok)

	// a stalled response holds
	`GDN_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

endmodule

bind gregorian_day_number_converter gdn_checker u_gdn_checker (.*);

/* sim/tb_gregorian_day_number_converter.sv */
// self-checking testbench for the gregorian date <-> julian day number converter
module tb_gregorian_day_number_converter;
	timeunit 1ns;
	timeprecision 1ps;

	import gdn_pkg::*;

	// one request as it goes in, one response as it comes out
	typedef struct packed {
		action_t act;
		year_t   year;
		month_t  month;
		day_t    day;
		dn_t     dn;
	} req_t;

	typedef struct packed {
		dn_t    dn;
		year_t  year;
		month_t month;
		day_t   day;
		wd_t    wd;
		logic   leap;
		logic   oor;
	} rsp_t;

	// directed row: the request, and the response typed in when it is obvious
	typedef struct packed {
		req_t rq;
		bit   hand_checked;
		rsp_t rs;
	} row_t;

	localparam int     N_RANDOM      = 480;
	localparam int     QUIET_TAIL    = 100;
	localparam int     WATCHDOG_MAX  = 1000;
	localparam int     DRAIN_CYCLES  = 30;
	localparam longint DN_TOP        = DAY_NUMBER_MAX;
	localparam rsp_t   FLAGGED       = '{oor: 1'b1, default: '0};
	localparam rsp_t   PREDICT       = '0;

	localparam int N_DIRECTED = 25;
	localparam row_t DIRECTED [N_DIRECTED] = '{
		// day zero and the day before it
		'{'{ACT_TO_DAY_NUMBER, -15'sd4713, 4'd11, 5'd24, 23'd0}, 1'b1,
			'{23'd0, 15'sd0, 4'd0, 5'd0, 3'd0, 1'b0, 1'b0}},
		'{'{ACT_TO_DAY_NUMBER, -15'sd4713, 4'd11, 5'd23, 23'd0}, 1'b1, FLAGGED},
		'{'{ACT_TO_DAY_NUMBER, -15'sd4713, 4'd1, 5'd1, 23'd0}, 1'b1, FLAGGED},
		// last supported date
		'{'{ACT_TO_DAY_NUMBER, 15'sd9999, 4'd12, 5'd31, 23'd0}, 1'b1,
			'{23'd5373484, 15'sd0, 4'd0, 5'd0, 3'd0, 1'b0, 1'b0}},
		'{'{ACT_TO_DAY_NUMBER, 15'sd2000, 4'd1, 5'd1, 23'd0}, 1'b1,
			'{23'd2451545, 15'sd0, 4'd0, 5'd0, 3'd0, 1'b1, 1'b0}},
		// years outside the range, down to the extremes of the field
		'{'{ACT_TO_DAY_NUMBER, 15'sd10000, 4'd1, 5'd1, 23'd0}, 1'b1, FLAGGED},
		'{'{ACT_TO_DAY_NUMBER, -15'sd4714, 4'd12, 5'd31, 23'd0}, 1'b1, FLAGGED},
		'{'{ACT_TO_DAY_NUMBER, 15'h4000, 4'd1, 5'd1, 23'd0}, 1'b1, FLAGGED},
		'{'{ACT_TO_DAY_NUMBER, 15'h3fff, 4'd6, 5'd15, 23'd0}, 1'b1, FLAGGED},
		// bad month and day codes
		'{'{ACT_TO_DAY_NUMBER, 15'sd2020, 4'd0, 5'd10, 23'd0}, 1'b1, FLAGGED},
		'{'{ACT_TO_DAY_NUMBER, 15'sd2020, 4'd13, 5'd10, 23'd0}, 1'b1, FLAGGED},
		'{'{ACT_TO_DAY_NUMBER, 15'sd2020, 4'd15, 5'd31, 23'd0}, 1'b1, FLAGGED},
		'{'{ACT_TO_DAY_NUMBER, 15'sd2020, 4'd5, 5'd0, 23'd0}, 1'b1, FLAGGED},
		// day past month end runs on, century and year zero leap rules
		'{'{ACT_TO_DAY_NUMBER, 15'sd2001, 4'd2, 5'd31, 23'd0}, 1'b0, PREDICT},
		'{'{ACT_TO_DAY_NUMBER, 15'sd1900, 4'd2, 5'd29, 23'd0}, 1'b0, PREDICT},
		'{'{ACT_TO_DAY_NUMBER, 15'sd0, 4'd3, 5'd1, 23'd0}, 1'b0, PREDICT},
		'{'{ACT_TO_DAY_NUMBER, -15'sd1, 4'd12, 5'd31, 23'd0}, 1'b0, PREDICT},
		'{'{ACT_TO_DAY_NUMBER, -15'sd100, 4'd6, 5'd15, 23'd0}, 1'b0, PREDICT},
		// number to date at both ends, just past the top, and all ones
		'{'{ACT_TO_DATE, 15'sd0, 4'd0, 5'd0, 23'd0}, 1'b1,
			'{23'd0, -15'sd4713, 4'd11, 5'd24, 3'd1, 1'b0, 1'b0}},
		'{'{ACT_TO_DATE, 15'sd0, 4'd0, 5'd0, 23'd5373484}, 1'b1,
			'{23'd0, 15'sd9999, 4'd12, 5'd31, 3'd5, 1'b0, 1'b0}},
		'{'{ACT_TO_DATE, 15'sd0, 4'd0, 5'd0, 23'd5373485}, 1'b1, FLAGGED},
		'{'{ACT_TO_DATE, 15'h7fff, 4'hf, 5'h1f, 23'h7fffff}, 1'b1, FLAGGED},
		'{'{ACT_TO_DATE, 15'sd0, 4'd0, 5'd0, 23'd2451545}, 1'b1,
			'{23'd0, 15'sd2000, 4'd1, 5'd1, 3'd6, 1'b1, 1'b0}},
		// leap day of a 400 year, and the turn into year zero
		'{'{ACT_TO_DATE, 15'sd0, 4'd0, 5'd0, 23'd2451604}, 1'b0, PREDICT},
		'{'{ACT_TO_DATE, 15'sd0, 4'd0, 5'd0, 23'd1721060}, 1'b0, PREDICT}
	};

	// clock, reset and the block's ports; the driven inputs are known from time zero
	logic    clk           = 1'b0;
	logic    arst_n        = 1'b0;
	logic    req_valid     = 1'b0;
	logic    req_ready;
	action_t action        = ACT_TO_DAY_NUMBER;
	year_t   year_in       = '0;
	month_t  month_in      = '0;
	day_t    day_in        = '0;
	dn_t     day_number_in = '0;
	logic    rsp_valid;
	logic    rsp_ready     = 1'b0;
	dn_t     day_number_out;
	year_t   year_out;
	month_t  month_out;
	day_t    day_out;
	wd_t     weekday;
	logic    leap_flag;
	logic    range_err;

	rsp_t pending_results [$];
	int   mismatch_count = 0;
	int   responses_seen = 0;
	int   n_to_number    = 0;
	int   n_to_date      = 0;
	int   n_flagged      = 0;
	int   quiet_cycles   = 0;
	// shared by both sides: random bursts of idling allowed
	bit   idle_on        = 1'b1;

	always #1 clk = ~clk;

	gregorian_day_number_converter DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.action         (action),
		.year_in        (year_in),
		.month_in       (month_in),
		.day_in         (day_in),
		.day_number_in  (day_number_in),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.day_number_out (day_number_out),
		.year_out       (year_out),
		.month_out      (month_out),
		.day_out        (day_out),
		.weekday        (weekday),
		.leap_flag      (leap_flag),
		.range_err      (range_err)
	);

	// division rounding toward minus infinity
	function automatic longint floor_quot(longint num, longint den);
		longint q;
		q = num / den;
		if ((num % den != 0) && ((num < 0) != (den < 0)))
			q = q - 1;
		return q;
	endfunction

	// gregorian leap rule, also for negative astronomical years
	function automatic logic gregorian_leap(longint yr);
		if (yr % 400 == 0)
			return 1'b1;
		if (yr % 100 == 0)
			return 1'b0;
		return (yr % 4 == 0);
	endfunction

	// expected response for one request
	function automatic rsp_t calendar_convert(req_t r);
		rsp_t   o;
		longint yr, mo, dy, a, y, m, jdn;
		longint j, g, dg, c, dc, b, db, da, md;
		o = '0;
		if (r.act == ACT_TO_DAY_NUMBER) begin
			yr = r.year;
			mo = r.month;
			dy = r.day;
			if (yr < YEAR_MIN || yr > YEAR_MAX || mo < 1 || mo > 12 || dy < 1) begin
				o.oor = 1'b1;
			end else begin
				// shift to a march-based year starting 4800 years back
				a = (14 - mo) / 12;
				y = yr + 4800 - a;
				m = mo + 12 * a - 3;
				jdn = dy + floor_quot(153 * m + 2, 5) + 365 * y + floor_quot(y, 4)
					- floor_quot(y, 100) + floor_quot(y, 400) - 32045;
				if (jdn < 0 || jdn > DN_TOP) begin
					o.oor = 1'b1;
				end else begin
					o.dn = dn_t'(jdn);
					o.leap = gregorian_leap(yr);
				end
			end
		end else begin
			jdn = r.dn;
			if (jdn > DN_TOP) begin
				o.oor = 1'b1;
			end else begin
				// peel off 400, 100, 4 and 1 year cycles
				j = jdn + 32044;
				g = j / 146097;
				dg = j % 146097;
				c = (dg / 36524 + 1) * 3 / 4;
				dc = dg - c * 36524;
				b = dc / 1461;
				db = dc % 1461;
				a = (db / 365 + 1) * 3 / 4;
				da = db - a * 365;
				y = g * 400 + c * 100 + b * 4 + a;
				md = (da * 5 + 308) / 153 - 2;
				dy = da - (md + 4) * 153 / 5 + 122;
				yr = y - 4800 + (md + 2) / 12;
				o.year = year_t'(yr);
				o.month = month_t'((md + 2) % 12 + 1);
				o.day = day_t'(dy + 1);
				o.wd = wd_t'(jdn % 7 + 1);
				o.leap = gregorian_leap(yr);
			end
		end
		return o;
	endfunction

	// mostly well-formed dates and day numbers, the rest raw noise
	function automatic req_t random_request();
		req_t        r;
		int unsigned pick;
		// every field random first, so the unused ones toggle too
		r.act = action_t'($urandom_range(0, 1));
		r.year = year_t'($urandom);
		r.month = month_t'($urandom);
		r.day = day_t'($urandom);
		r.dn = dn_t'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			r.act = ACT_TO_DAY_NUMBER;
			if ($urandom_range(0, 9) == 0)
				r.year = $urandom_range(0, 1) ? YEAR_MIN : YEAR_MAX;
			else
				r.year = year_t'(int'($urandom_range(0, int'(YEAR_MAX) - int'(YEAR_MIN)))
					+ int'(YEAR_MIN));
			r.month = month_t'($urandom_range(1, MONTH_MAX));
			r.day = ($urandom_range(0, 7) == 0) ? day_t'($urandom_range(29, 31))
				: day_t'($urandom_range(1, 28));
		end else if (pick < 85) begin
			r.act = ACT_TO_DATE;
			case ($urandom_range(0, 9))
				0: r.dn = dn_t'($urandom_range(0, 400));
				1: r.dn = DAY_NUMBER_MAX - dn_t'($urandom_range(0, 400));
				default: r.dn = dn_t'($urandom_range(0, int'(DAY_NUMBER_MAX)));
			endcase
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at response %0d: %s", responses_seen, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want)
			flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// present one request, hold it until taken, then maybe go quiet for a burst
	task automatic offer(input req_t r, input bit hand_checked, input rsp_t typed);
		rsp_t want;
		req_valid <= 1'b1;
		action <= r.act;
		year_in <= r.year;
		month_in <= r.month;
		day_in <= r.day;
		day_number_in <= r.dn;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		want = hand_checked ? typed : calendar_convert(r);
		pending_results.push_back(want);
		if (want.oor)
			n_flagged++;
		else if (r.act == ACT_TO_DAY_NUMBER)
			n_to_number++;
		else
			n_to_date++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// response side: ready and stalled in random stretches, stalls only while idling is allowed
	initial begin
		forever begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// compare each response with the oldest pending one
	always @(posedge clk) begin : response_check
		rsp_t got, want;
		if (arst_n && rsp_valid && rsp_ready) begin
			got = '{day_number_out, year_out, month_out, day_out, weekday, leap_flag,
				range_err};
			if (pending_results.size() == 0) begin
				flag_mismatch("response with no request pending");
			end else begin
				want = pending_results.pop_front();
				check_field("day_number_out", got.dn, want.dn);
				check_field("year_out", got.year, want.year);
				check_field("month_out", got.month, want.month);
				check_field("day_out", got.day, want.day);
				check_field("weekday", got.wd, want.wd);
				check_field("leap_flag", got.leap, want.leap);
				check_field("range_err", got.oor, want.oor);
			end
			responses_seen++;
		end
	end

	// watchdog: too long without a handshake on either side ends the run
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("watchdog: no handshake for %0d cycles, %0d responses pending",
				quiet_cycles, pending_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// stimulus: reset, the directed rows, then random requests
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			offer(DIRECTED[i].rq, DIRECTED[i].hand_checked, DIRECTED[i].rs);

		for (int i = 0; i < N_RANDOM; i++) begin
			// idle-free stretch every so often, and none at all near the end
			idle_on = (i < N_RANDOM - QUIET_TAIL) && ((i % 120) < 90);
			offer(random_request(), 1'b0, PREDICT);
		end
		req_valid <= 1'b0;

		// let the pipeline drain, then watch for strays
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d directed and %0d random requests, %0d responses checked",
			N_DIRECTED, N_RANDOM, responses_seen);
		$display("date to number %0d, number to date %0d, out of range %0d, mismatches %0d",
			n_to_number, n_to_date, n_flagged, mismatch_count);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
